// File: rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared geometry constants, item codes and the glyph store write type.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

    // Console geometry.
    localparam int GLYPH_COUNT = 128;
    localparam int TEXT_ROWS   = 30;
    localparam int TEXT_COLS   = 80;
    localparam int CELL_HEIGHT = 16;

    // Derived widths. Each glyph takes four 32-bit words in the store.
    localparam int WORDS_PER_GLYPH = 4;
    localparam int CH_W            = $clog2(GLYPH_COUNT);
    localparam int STORE_DEPTH     = GLYPH_COUNT * WORDS_PER_GLYPH;
    localparam int AW              = $clog2(STORE_DEPTH);
    localparam int ROW_W           = $clog2(CELL_HEIGHT);

    // Fixed field widths.
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;
    localparam int COLOUR_W     = 24;
    localparam int PROW_W       = 9;
    localparam int PCOL_W       = 10;
    localparam int CFG_IDX_W    = 1;

    // Input operation codes.
    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    // Write request into the glyph store.
    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [31:0]   data;
    } glyph_wr_t;

endpackage

`default_nettype wire

// File: rtl/text_console_glyph_renderer_unit.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Draws characters from a glyph store into an 80x30 text grid and emits one
// item per glyph row, plus scroll and clear items for downstream execution.
// ----------------------------------------------------------------------------
// A draw item produces CELL_HEIGHT row items, one per cycle while the
// output is not stalled, because each row needs one read of the glyph
// store's single read port; a draw that runs past the last text row adds
// one scroll item. The next input item is taken in the cycle the final
// result of the current one is handed to the output register. A load item
// only writes the glyph store; a clear item emits one clear item. Output
// back-pressure stalls draw, scroll and clear steps. The glyph store is not
// cleared after reset; a glyph must be loaded before it is drawn.
`default_nettype none

module text_console_glyph_renderer_unit
    import tcgr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // Input items.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: char_code[6:0], word_index[8:7], glyph_word[40:9], zero fill
    input  wire logic [47:0]          s_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]           s_tuser,

    // Result items.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tdata: pixel_row[8:0], pixel_col[18:9], row_bits[26:19],
    //        fg_value[50:27], bg_value[74:51], zero fill
    output logic [79:0]               m_tdata,
    // tuser: kind[1:0]
    output logic [1:0]                m_tuser,
    output logic                      m_tlast,

    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOUR_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_SCROLL,
        ST_CLEAR
    } state_t;

    // Registers.
    state_t                  st_reg, st_next;
    logic [CURSOR_ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [CURSOR_COL_W-1:0] cur_col_reg, cur_col_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic                    scroll_reg, scroll_next;
    logic [PROW_W-1:0]       prow_base_reg, prow_base_next;
    logic [PCOL_W-1:0]       pcol_reg, pcol_next;
    logic [COLOUR_W-1:0]     fg_reg, bg_reg;

    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_kind_reg, m_kind_next;
    logic [PROW_W-1:0]       m_prow_reg, m_prow_next;
    logic [PCOL_W-1:0]       m_pcol_reg, m_pcol_next;
    logic [7:0]              m_bits_reg, m_bits_next;
    logic [COLOUR_W-1:0]     m_fg_reg, m_fg_next;
    logic [COLOUR_W-1:0]     m_bg_reg, m_bg_next;
    logic                    m_last_reg, m_last_next;

    // Input fields.
    logic [1:0]              in_op;
    logic [6:0]              in_char;
    logic [1:0]              in_widx;
    logic [31:0]             in_word;
    logic [CH_W-1:0]         in_ch;

    // Control.
    logic                    s_acc;
    logic                    emit_ok;
    logic                    row_last;
    logic                    done_now;
    logic [7:0]              col_inc;
    logic [5:0]              row_inc;
    logic                    col_wrap;
    logic                    row_wrap;
    logic [7:0]              glyph_byte;

    glyph_wr_t               store_wr;
    logic [AW-1:0]           rd_addr;
    logic [31:0]             rd_data;

    assign in_op   = s_tuser;
    assign in_char = s_tdata[6:0];
    assign in_widx = s_tdata[8:7];
    assign in_word = s_tdata[40:9];
    assign in_ch   = CH_W'(in_char % GLYPH_COUNT);

    assign s_acc    = s_tvalid && s_tready;
    assign emit_ok  = !m_valid_reg || m_tready;
    assign row_last = (row_reg == ROW_W'(CELL_HEIGHT - 1));

    // The engine is free after this edge when its final result enters the output register now.
    assign done_now = emit_ok &&
                      (((st_reg == ST_DRAW) && row_last && !scroll_reg) ||
                       (st_reg == ST_SCROLL) || (st_reg == ST_CLEAR));
    assign s_tready = (st_reg == ST_IDLE) || done_now;

    assign cfg_ready = 1'b1;

    // Cursor advance, worked out ahead of the draw.
    assign col_inc  = {1'b0, cur_col_reg} + 8'd1;
    assign row_inc  = {1'b0, cur_row_reg} + 6'd1;
    assign col_wrap = (col_inc >= 8'(TEXT_COLS));
    assign row_wrap = (row_inc >= 6'(TEXT_ROWS));

    // Byte of the glyph word for the current row, top row in the high byte.
    always_comb begin
        case (row_reg[1:0])
            2'd0:    glyph_byte = rd_data[31:24];
            2'd1:    glyph_byte = rd_data[23:16];
            2'd2:    glyph_byte = rd_data[15:8];
            default: glyph_byte = rd_data[7:0];
        endcase
    end

    // Sequencer and result formation.
    always_comb begin
        st_next        = st_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        ch_next        = ch_reg;
        row_next       = row_reg;
        scroll_next    = scroll_reg;
        prow_base_next = prow_base_reg;
        pcol_next      = pcol_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_prow_next  = m_prow_reg;
        m_pcol_next  = m_pcol_reg;
        m_bits_next  = m_bits_reg;
        m_fg_next    = m_fg_reg;
        m_bg_next    = m_bg_reg;
        m_last_next  = m_last_reg;

        store_wr.en   = 1'b0;
        store_wr.addr = AW'({in_ch, 2'b00}) + AW'(in_widx);
        store_wr.data = in_word;

        // Emit the current step's result when the output register frees up.
        case (st_reg)
            ST_DRAW: begin
                if (emit_ok) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ROW;
                    m_prow_next  = prow_base_reg + PROW_W'(row_reg);
                    m_pcol_next  = pcol_reg;
                    m_bits_next  = glyph_byte;
                    m_fg_next    = fg_reg;
                    m_bg_next    = bg_reg;
                    m_last_next  = row_last && !scroll_reg;
                    if (row_last) begin
                        st_next = scroll_reg ? ST_SCROLL : ST_IDLE;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end
            ST_SCROLL, ST_CLEAR: begin
                if (emit_ok) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = (st_reg == ST_SCROLL) ? KIND_SCROLL : KIND_CLEAR;
                    m_prow_next  = '0;
                    m_pcol_next  = '0;
                    m_bits_next  = '0;
                    m_fg_next    = '0;
                    m_bg_next    = bg_reg;
                    m_last_next  = 1'b1;
                    st_next      = ST_IDLE;
                end
            end
            default: begin
            end
        endcase

        // Take a new item.
        if (s_acc) begin
            case (in_op)
                OP_DRAW: begin
                    st_next        = ST_DRAW;
                    ch_next        = in_ch;
                    row_next       = '0;
                    scroll_next    = col_wrap && row_wrap;
                    prow_base_next = PROW_W'(cur_row_reg * CELL_HEIGHT);
                    pcol_next      = PCOL_W'({cur_col_reg, 3'b000});
                    if (col_wrap) begin
                        cur_col_next = '0;
                        cur_row_next = row_wrap ? CURSOR_ROW_W'(TEXT_ROWS - 1)
                                                : CURSOR_ROW_W'(row_inc);
                    end else begin
                        cur_col_next = CURSOR_COL_W'(col_inc);
                    end
                end
                OP_LOAD: begin
                    store_wr.en = 1'b1;
                    st_next     = ST_IDLE;
                end
                OP_CLEAR: begin
                    st_next      = ST_CLEAR;
                    cur_row_next = '0;
                    cur_col_next = '0;
                end
                default: begin
                    st_next = ST_IDLE;
                end
            endcase
        end
    end

    // The read address follows the next row so the data matches row_reg.
    assign rd_addr = AW'({ch_next, 2'b00}) + AW'(row_next >> 2);

    tcgr_glyph_store u_store (
        .aclk    (aclk),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // State, configuration and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            fg_reg      <= '0;
            bg_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FG:  fg_reg <= cfg_data;
                    CFG_BG:  bg_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        ch_reg        <= ch_next;
        row_reg       <= row_next;
        scroll_reg    <= scroll_next;
        prow_base_reg <= prow_base_next;
        pcol_reg      <= pcol_next;
        m_kind_reg    <= m_kind_next;
        m_prow_reg    <= m_prow_next;
        m_pcol_reg    <= m_pcol_next;
        m_bits_reg    <= m_bits_next;
        m_fg_reg      <= m_fg_next;
        m_bg_reg      <= m_bg_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_bg_reg, m_fg_reg, m_bits_reg, m_pcol_reg, m_prow_reg};

`ifndef SYNTHESIS
    // A draw item starts at the top row of its cell.
    a_draw_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_op == OP_DRAW) |=> (st_reg == ST_DRAW) && (row_reg == '0))
        else $error("draw did not start at the top glyph row");

    // A glyph row marked last must be the bottom row of the cell.
    a_row_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DRAW) && emit_ok && m_last_next |-> row_last && !scroll_reg)
        else $error("glyph row flagged last before the bottom row");

    // The scroll step runs only for a draw that wrapped past the last row.
    a_scroll_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_SCROLL) |-> scroll_reg)
        else $error("scroll step without a wrap past the last row");

    // The cursor stays inside the text grid.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_row_reg < CURSOR_ROW_W'(TEXT_ROWS)) &&
        ({1'b0, cur_col_reg} < 8'(TEXT_COLS)))
        else $error("cursor outside the text grid");
`endif

endmodule

`default_nettype wire

// File: rtl/tcgr_glyph_store.sv
// ----------------------------------------------------------------------------
// Glyph store
// Single-port-write, single-port-read memory of glyph words with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_glyph_store
    import tcgr_pkg::*;
(
    input  wire logic           aclk,
    input  wire glyph_wr_t      wr,
    input  wire logic [AW-1:0]  rd_addr,
    output logic [31:0]         rd_data
);

    logic [31:0] mem [STORE_DEPTH];
    logic [31:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
